// ----- hw/rtl/matrix_scale_extract_assert.svh -----
// Assertion macros shared by the scale extraction RTL.
`ifndef MATRIX_SCALE_EXTRACT_ASSERT_SVH
`define MATRIX_SCALE_EXTRACT_ASSERT_SVH

// Antecedent and consequent are checked at the same clock edge.
`define MSE_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent is checked at the clock edge after the antecedent.
`define MSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mse_pkg.sv -----
// Constants and types of the matrix scale extraction block.
package mse_pkg;

    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-1:0] ADDR_EPS = '0;
    localparam logic [31:0] EPS_RESET = 32'd1;
    localparam logic [31:0] SCALE_MAX = 32'h7FFF_FFFF;

    localparam int MUL_LAT    = 3;
    localparam int DIV_STEPS  = 64;
    localparam int ROOT_STEPS = 32;

    // Column pairs for the cross products: a x b, a x c, b x c.
    localparam int PAIR_U [3] = '{0, 0, 1};
    localparam int PAIR_V [3] = '{1, 2, 2};

    typedef struct packed {
        logic [63:0] asq;
        logic [63:0] bsq;
        logic [63:0] csq;
        logic        aok;
        logic        bok;
    } t_side;

    typedef struct packed {
        t_side s;
        logic  dneg;
    } t_side2;

    typedef struct packed {
        t_side2            s;
        logic [2:0][127:0] n;
    } t_side3;

endpackage

// ----- hw/rtl/mse_mul.sv -----
// Unsigned multiplier cut into 32 by 32 bit partial products over three stages.
module mse_mul #(
    parameter int WA = 65,
    parameter int WB = 65
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WA-1:0]    i_a,
    input  logic [WB-1:0]    i_b,
    output logic [WA+WB-1:0] o_p
);
    localparam int NA = (WA + 31) / 32;
    localparam int NB = (WB + 31) / 32;
    localparam int WR = 32 * (NB + 1);
    localparam int WS = 32 * (NA + NB);

    logic [32*NA-1:0] w_a;
    logic [32*NB-1:0] w_b;
    logic [63:0]      r_pp  [NA][NB];
    logic [WR-1:0]    w_row [NA];
    logic [WR-1:0]    r_row [NA];
    logic [WS-1:0]    w_acc;
    logic [WS-1:0]    r_acc;

    assign w_a = (32*NA)'(i_a);
    assign w_b = (32*NB)'(i_b);

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            w_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                w_row[i] = w_row[i] + (WR'(r_pp[i][j]) << (32 * j));
            end
        end
        w_acc = '0;
        for (int i = 0; i < NA; i++) begin
            w_acc = w_acc + (WS'(r_row[i]) << (32 * i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= 64'(w_a[32*i +: 32]) * 64'(w_b[32*j +: 32]);
                end
                r_row[i] <= w_row[i];
            end
            r_acc <= w_acc;
        end
    end

    assign o_p = r_acc[WA+WB-1:0];

endmodule

// ----- hw/rtl/matrix_scale_extract.sv -----
// Top level of the matrix scale extraction pipeline.
//
// Each input item is the 3x3 linear part of a transform, nine Q16.16 elements
// i_m00 .. i_m22. The block orthogonalises columns 0, 1 and 2 in that order and
// returns their lengths as Q16.16 scales, negated together when a full, usable basis is
// left-handed. An item is taken at a rising edge with i_valid high and o_stall
// low; a result item leaves at an edge with o_valid high and i_stall low.
// Between acceptance and o_valid the item passes through every pipeline stage,
// among them the 64-step quotient pipeline and the 32-step square root pipeline.
// Throughput is one item per cycle while the receiver takes results.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// o_stall rises, so nothing is lost or repeated; bubbles stay where they are.
// The squared-length threshold is written over the APB port at byte address 0
// and should only be changed while no item is in flight.
// Reset is synchronous: it empties the pipeline and sets the threshold to one.
// There is no clearing pass and no other state.
`include "matrix_scale_extract_assert.svh"

module matrix_scale_extract (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [31:0]         i_m00,
    input  logic signed [31:0]         i_m01,
    input  logic signed [31:0]         i_m02,
    input  logic signed [31:0]         i_m10,
    input  logic signed [31:0]         i_m11,
    input  logic signed [31:0]         i_m12,
    input  logic signed [31:0]         i_m20,
    input  logic signed [31:0]         i_m21,
    input  logic signed [31:0]         i_m22,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [31:0]         o_scale_x,
    output logic signed [31:0]         o_scale_y,
    output logic signed [31:0]         o_scale_z,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mse_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import mse_pkg::*;

    localparam int LAT = 4 + MUL_LAT + 2 + MUL_LAT + 1 + DIV_STEPS + 1 + ROOT_STEPS + 1;

    // Pipeline control: every stage moves together unless a finished result
    // is being held by the receiver.
    logic           w_adv;
    logic           w_cfg_wr;
    logic [31:0]    r_eps;
    logic [63:0]    w_eps64;
    logic [LAT-1:0] r_vld;

    assign w_adv    = !(r_vld[LAT-1] && i_stall);
    assign o_stall  = !w_adv;
    assign o_valid  = r_vld[LAT-1];
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_EPS);
    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_EPS) ? r_eps : '0;
    assign w_eps64  = {32'h0, r_eps};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_eps <= EPS_RESET;
        end else begin
            if (w_adv) begin
                r_vld <= {r_vld[LAT-2:0], i_valid};
            end
            if (w_cfg_wr) begin
                r_eps <= pwdata;
            end
        end
    end

    // Stage 1: capture the matrix. Element of row r, column c sits at 3*r+c.
    logic signed [31:0] r1_m [9];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_m[0] <= i_m00;
            r1_m[1] <= i_m01;
            r1_m[2] <= i_m02;
            r1_m[3] <= i_m10;
            r1_m[4] <= i_m11;
            r1_m[5] <= i_m12;
            r1_m[6] <= i_m20;
            r1_m[7] <= i_m21;
            r1_m[8] <= i_m22;
        end
    end

    // Stage 2: all 32 by 32 bit products of squared lengths and cross products.
    logic signed [63:0] r2_sq [3][3];
    logic signed [63:0] r2_cp [3][3][2];
    logic signed [31:0] r2_a  [3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    r2_sq[c][r] <= r1_m[r*3+c] * r1_m[r*3+c];
                end
            end
            for (int p = 0; p < 3; p++) begin
                for (int i = 0; i < 3; i++) begin
                    r2_cp[p][i][0] <= r1_m[((i == 2) ? 0 : i + 1) * 3 + PAIR_U[p]]
                                    * r1_m[((i == 0) ? 2 : i - 1) * 3 + PAIR_V[p]];
                    r2_cp[p][i][1] <= r1_m[((i == 0) ? 2 : i - 1) * 3 + PAIR_U[p]]
                                    * r1_m[((i == 2) ? 0 : i + 1) * 3 + PAIR_V[p]];
                end
            end
            for (int r = 0; r < 3; r++) begin
                r2_a[r] <= r1_m[r*3];
            end
        end
    end

    // Stage 3: exact squared lengths (Q32.32) and the cross product components.
    logic        [63:0] r3_sq [3];
    logic signed [64:0] r3_cr [3][3];
    logic signed [31:0] r3_a  [3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int c = 0; c < 3; c++) begin
                r3_sq[c] <= $unsigned(r2_sq[c][0]) + $unsigned(r2_sq[c][1])
                          + $unsigned(r2_sq[c][2]);
            end
            for (int p = 0; p < 3; p++) begin
                for (int i = 0; i < 3; i++) begin
                    r3_cr[p][i] <= 65'(r2_cp[p][i][0]) - 65'(r2_cp[p][i][1]);
                end
            end
            r3_a <= r2_a;
        end
    end

    // Stage 4: magnitudes and signs feed the wide multipliers. The determinant
    // is a . (b x c), so its terms pair column a with the b x c components.
    logic [64:0] r4_cabs [3][3];
    logic [31:0] r4_aabs [3];
    logic [2:0]  r4_dsg;
    t_side       r4_side;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int p = 0; p < 3; p++) begin
                for (int i = 0; i < 3; i++) begin
                    r4_cabs[p][i] <= r3_cr[p][i][64] ? $unsigned(-r3_cr[p][i])
                                                     : $unsigned(r3_cr[p][i]);
                end
            end
            for (int i = 0; i < 3; i++) begin
                r4_aabs[i] <= r3_a[i][31] ? $unsigned(-r3_a[i]) : $unsigned(r3_a[i]);
                r4_dsg[i]  <= r3_a[i][31] ^ r3_cr[2][i][64];
            end
            r4_side.asq <= r3_sq[0];
            r4_side.bsq <= r3_sq[1];
            r4_side.csq <= r3_sq[2];
            r4_side.aok <= r3_sq[0] > w_eps64;
            r4_side.bok <= r3_sq[1] > w_eps64;
        end
    end

    // Stages 5 to 7: squares of the cross components and determinant terms.
    logic [129:0] w_csq [3][3];
    logic [96:0]  w_dp  [3];
    t_side        r_sda  [MUL_LAT];
    logic [2:0]   r_dsga [MUL_LAT];

    for (genvar gp = 0; gp < 3; gp++) begin : g_sq_p
        for (genvar gi = 0; gi < 3; gi++) begin : g_sq_i
            mse_mul #(.WA(65), .WB(65)) u_sq (
                .i_clk (i_clk),
                .i_en  (w_adv),
                .i_a   (r4_cabs[gp][gi]),
                .i_b   (r4_cabs[gp][gi]),
                .o_p   (w_csq[gp][gi])
            );
        end
    end

    for (genvar gi = 0; gi < 3; gi++) begin : g_det
        mse_mul #(.WA(32), .WB(65)) u_dp (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_a   (r4_aabs[gi]),
            .i_b   (r4_cabs[2][gi]),
            .o_p   (w_dp[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sda[0]  <= r4_side;
            r_dsga[0] <= r4_dsg;
            for (int k = 1; k < MUL_LAT; k++) begin
                r_sda[k]  <= r_sda[k-1];
                r_dsga[k] <= r_dsga[k-1];
            end
        end
    end

    // Stage 8: the three cross product norms and the signed determinant.
    // Each norm is at most |u|^2 |v|^2, which stays below 2^128.
    logic [98:0]  w_det;
    logic [98:0]  r8_det;
    logic [127:0] r8_n [3];
    t_side        r8_side;

    always_comb begin
        w_det = '0;
        for (int i = 0; i < 3; i++) begin
            if (r_dsga[MUL_LAT-1][i]) begin
                w_det = w_det - 99'(w_dp[i]);
            end else begin
                w_det = w_det + 99'(w_dp[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int p = 0; p < 3; p++) begin
                r8_n[p] <= 128'(w_csq[p][0] + w_csq[p][1] + w_csq[p][2]);
            end
            r8_det  <= w_det;
            r8_side <= r_sda[MUL_LAT-1];
        end
    end

    // Stage 9: determinant magnitude; stages 10 to 12 square it.
    logic [96:0]  r9_dabs;
    t_side3       r9_side;
    logic [193:0] w_d2;
    t_side3       r_sdb [MUL_LAT];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r9_dabs        <= 97'(r8_det[98] ? -r8_det : r8_det);
            r9_side.s.s    <= r8_side;
            r9_side.s.dneg <= r8_det[98];
            for (int p = 0; p < 3; p++) begin
                r9_side.n[p] <= r8_n[p];
            end
            r_sdb[0] <= r9_side;
            for (int k = 1; k < MUL_LAT; k++) begin
                r_sdb[k] <= r_sdb[k-1];
            end
        end
    end

    mse_mul #(.WA(97), .WB(97)) u_d2 (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_a   (r9_dabs),
        .i_b   (r9_dabs),
        .o_p   (w_d2)
    );

    // Quotient pipeline, three lanes, one quotient bit per stage:
    //   lane 0: |a x b|^2 / |a|^2, the residual of b after a;
    //   lane 1: det^2 / |a x b|^2, the residual of c after a and b;
    //   lane 2: |a x c|^2 / |a|^2, or |b x c|^2 / |b|^2 when a is unusable.
    // Every quotient that is used fits in 64 bits, so the upper numerator half
    // is already below the divisor and seeds the remainder.
    logic [193:0] w_pn [3];
    logic [127:0] w_pd [3];
    t_side3       w_sb;

    logic [127:0] r_dv_r  [DIV_STEPS+1][3];
    logic [63:0]  r_dv_lo [DIV_STEPS+1][3];
    logic [127:0] r_dv_d  [DIV_STEPS+1][3];
    logic [63:0]  r_dv_q  [DIV_STEPS+1][3];
    t_side2       r_dv_sd [DIV_STEPS+1];

    assign w_sb = r_sdb[MUL_LAT-1];

    always_comb begin
        w_pn[0] = 194'(w_sb.n[0]);
        w_pd[0] = 128'(w_sb.s.s.asq);
        w_pn[1] = w_d2;
        w_pd[1] = w_sb.n[0];
        if (w_sb.s.s.aok) begin
            w_pn[2] = 194'(w_sb.n[1]);
            w_pd[2] = 128'(w_sb.s.s.asq);
        end else begin
            w_pn[2] = 194'(w_sb.n[2]);
            w_pd[2] = 128'(w_sb.s.s.bsq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int l = 0; l < 3; l++) begin
                r_dv_r[0][l]  <= w_pn[l][191:64];
                r_dv_lo[0][l] <= w_pn[l][63:0];
                r_dv_d[0][l]  <= w_pd[l];
                r_dv_q[0][l]  <= '0;
            end
            r_dv_sd[0] <= w_sb.s;
        end
    end

    for (genvar gk = 0; gk < DIV_STEPS; gk++) begin : g_div
        logic [128:0] w_t  [3];
        logic         w_ge [3];

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                w_t[l]  = {r_dv_r[gk][l], r_dv_lo[gk][l][63]};
                w_ge[l] = w_t[l] >= {1'b0, r_dv_d[gk][l]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                for (int l = 0; l < 3; l++) begin
                    r_dv_r[gk+1][l]  <= w_ge[l] ? 128'(w_t[l] - {1'b0, r_dv_d[gk][l]})
                                                : w_t[l][127:0];
                    r_dv_lo[gk+1][l] <= {r_dv_lo[gk][l][62:0], 1'b0};
                    r_dv_d[gk+1][l]  <= r_dv_d[gk][l];
                    r_dv_q[gk+1][l]  <= {r_dv_q[gk][l][62:0], w_ge[l]};
                end
                r_dv_sd[gk+1] <= r_dv_sd[gk];
            end
        end
    end

    // Root selection. A scale that must read zero is sent through the root
    // unit as a zero radicand. Only a full, usable basis may flip the signs.
    logic [63:0] w_q [3];
    t_side2      w_sd;
    logic [63:0] w_rin [3];
    logic        w_flip;

    assign w_sd = r_dv_sd[DIV_STEPS];
    for (genvar gl = 0; gl < 3; gl++) begin : g_q
        assign w_q[gl] = r_dv_q[DIV_STEPS][gl];
    end

    always_comb begin
        w_rin[0] = '0;
        w_rin[1] = '0;
        w_rin[2] = '0;
        w_flip   = 1'b0;
        if (w_sd.s.aok) begin
            w_rin[0] = w_sd.s.asq;
            if (w_q[0] > w_eps64) begin
                w_rin[1] = w_q[0];
                if (w_q[1] > w_eps64) begin
                    w_rin[2] = w_q[1];
                    w_flip   = w_sd.dneg;
                end
            end else if (w_q[2] > w_eps64) begin
                w_rin[2] = w_q[2];
            end
        end else if (w_sd.s.bok) begin
            // Without a usable first column no threshold applies to the third.
            w_rin[1] = w_sd.s.bsq;
            w_rin[2] = w_q[2];
        end else begin
            w_rin[2] = w_sd.s.csq;
        end
    end

    // Square root pipeline: two radicand bits and one root bit per stage.
    logic [63:0] r_rt_x    [ROOT_STEPS+1][3];
    logic [33:0] r_rt_rem  [ROOT_STEPS+1][3];
    logic [31:0] r_rt_res  [ROOT_STEPS+1][3];
    logic        r_rt_flip [ROOT_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int l = 0; l < 3; l++) begin
                r_rt_x[0][l]   <= w_rin[l];
                r_rt_rem[0][l] <= '0;
                r_rt_res[0][l] <= '0;
            end
            r_rt_flip[0] <= w_flip;
        end
    end

    for (genvar gk = 0; gk < ROOT_STEPS; gk++) begin : g_root
        logic [35:0] w_t   [3];
        logic [35:0] w_try [3];
        logic        w_ge  [3];

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                w_t[l]   = {r_rt_rem[gk][l], r_rt_x[gk][l][63:62]};
                w_try[l] = {2'b00, r_rt_res[gk][l], 2'b01};
                w_ge[l]  = w_t[l] >= w_try[l];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                for (int l = 0; l < 3; l++) begin
                    r_rt_x[gk+1][l]   <= {r_rt_x[gk][l][61:0], 2'b00};
                    r_rt_rem[gk+1][l] <= w_ge[l] ? 34'(w_t[l] - w_try[l]) : w_t[l][33:0];
                    r_rt_res[gk+1][l] <= {r_rt_res[gk][l][30:0], w_ge[l]};
                end
                r_rt_flip[gk+1] <= r_rt_flip[gk];
            end
        end
    end

    // Output register: saturate each root to Q16.16, then apply the flip.
    logic [31:0] w_sat [3];
    logic [31:0] r_out [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_sat[l] = r_rt_res[ROOT_STEPS][l][31] ? SCALE_MAX : r_rt_res[ROOT_STEPS][l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int l = 0; l < 3; l++) begin
                r_out[l] <= r_rt_flip[ROOT_STEPS] ? 32'(-w_sat[l]) : w_sat[l];
            end
        end
    end

    assign o_scale_x = $signed(r_out[0]);
    assign o_scale_y = $signed(r_out[1]);
    assign o_scale_z = $signed(r_out[2]);

    // A flip only happens with three nonzero scales, so signs always agree.
    `MSE_ASSERT_SAME(a_sign_neg, i_clk, i_rst_n, o_valid && o_scale_x[31],
        o_scale_y[31] && o_scale_z[31], "negative scale_x without negative y and z")
    `MSE_ASSERT_SAME(a_sign_pos, i_clk, i_rst_n, o_valid && !o_scale_x[31],
        !o_scale_y[31] && !o_scale_z[31], "negative scale without a flipped basis")
    `MSE_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !w_adv, $stable(r_vld),
        "pipeline valid bits moved while the output was held")
    `MSE_ASSERT_NEXT(a_cfg, i_clk, i_rst_n, w_cfg_wr && i_rst_n, r_eps == $past(pwdata),
        "threshold register not updated by a write")

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench of the matrix scale extraction block.
`timescale 1ns / 1ps

module tb_top;

    import mse_pkg::*;

    // Wide signed arithmetic for exact squared lengths, cross products and determinants.
    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic [31:0] e [9];  // row-major: element r, c sits at index 3*r + c
    } matrix_t;

    typedef struct {
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] sz;
    } scales_t;

    localparam int RUN_LIMIT = 600000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_m [9] = '{default: '0};
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_scale_x, o_scale_y, o_scale_z;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    always #5 i_clk = ~i_clk;

    matrix_scale_extract DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_m00(i_m[0]), .i_m01(i_m[1]), .i_m02(i_m[2]),
        .i_m10(i_m[3]), .i_m11(i_m[4]), .i_m12(i_m[5]),
        .i_m20(i_m[6]), .i_m21(i_m[7]), .i_m22(i_m[8]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_scale_x(o_scale_x), .o_scale_y(o_scale_y), .o_scale_z(o_scale_z),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // The threshold the predictor uses; it tracks every register write.
    logic [31:0] cur_eps = EPS_RESET;

    matrix_t pending_mats [$];
    scales_t expected_scales [$];
    int      mismatches = 0;

    // ------------------------------------------------------------------
    // Predictor: exact integer Gram-Schmidt on the three columns.
    // ------------------------------------------------------------------
    function automatic wide_t dot3(input wide_t u [3], input wide_t v [3]);
        return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    endfunction

    function automatic void cross3(input wide_t u [3], input wide_t v [3],
                                   output wide_t r [3]);
        r[0] = u[1] * v[2] - u[2] * v[1];
        r[1] = u[2] * v[0] - u[0] * v[2];
        r[2] = u[0] * v[1] - u[1] * v[0];
    endfunction

    // Floor quotient; only its low 64 bits are kept, as in the hardware.
    function automatic logic [63:0] quot64(input wide_t n, input wide_t d);
        logic [255:0] q;
        q = $unsigned(n) / $unsigned(d);
        return q[63:0];
    endfunction

    // Squared length of v with its component along u removed.
    function automatic logic [63:0] residual_sq(input wide_t u [3], input wide_t v [3],
                                                input wide_t usq);
        wide_t cr [3];
        cross3(u, v, cr);
        return quot64(dot3(cr, cr), usq);
    endfunction

    // Floor square root of a Q32.32 value as Q16.16, saturated.
    function automatic logic [31:0] root_sat(input logic [63:0] x);
        logic [63:0] rem, root, bitv;
        rem  = x;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return (root > {32'd0, SCALE_MAX}) ? SCALE_MAX : root[31:0];
    endfunction

    function automatic scales_t predict_scales(input matrix_t m, input logic [31:0] eps);
        wide_t       col [3][3];
        wide_t       asq, bsq, csq, nab, det;
        wide_t       ab [3], bc [3];
        logic [63:0] eps64, y2, z2;
        logic        flip;
        scales_t     s;
        eps64 = {32'd0, eps};
        flip  = 1'b0;
        s.sx  = '0;
        s.sy  = '0;
        s.sz  = '0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                col[c][r] = {{224{m.e[3*r+c][31]}}, m.e[3*r+c]};
        asq = dot3(col[0], col[0]);
        bsq = dot3(col[1], col[1]);
        csq = dot3(col[2], col[2]);
        if (asq[63:0] > eps64) begin
            s.sx = root_sat(asq[63:0]);
            y2   = residual_sq(col[0], col[1], asq);
            if (y2 > eps64) begin
                s.sy = root_sat(y2);
                cross3(col[0], col[1], ab);
                nab = dot3(ab, ab);
                cross3(col[1], col[2], bc);
                det = dot3(col[0], bc);
                z2  = quot64(det * det, nab);
                if (z2 > eps64) begin
                    s.sz = root_sat(z2);
                    flip = det[255];
                end
            end else begin
                // b collapses onto a, so c is measured against a alone.
                z2 = residual_sq(col[0], col[2], asq);
                if (z2 > eps64) s.sz = root_sat(z2);
            end
        end else if (bsq[63:0] > eps64) begin
            s.sy = root_sat(bsq[63:0]);
            s.sz = root_sat(residual_sq(col[1], col[2], bsq));
        end else begin
            s.sz = root_sat(csq[63:0]);
        end
        if (flip) begin
            s.sx = -s.sx;
            s.sy = -s.sy;
            s.sz = -s.sz;
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of random length separated by random gaps. The item
    // on the port is always the head of the pending queue.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_scales.push_back(predict_scales(pending_mats[0], cur_eps));
                void'(pending_mats.pop_front());
            end
            if (i_valid && o_stall) begin
                // A stalled item stays on the port unchanged.
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid  <= 1'b0;
            end else if (pending_mats.size() > 0) begin
                for (int k = 0; k < 9; k++) i_m[k] <= pending_mats[0].e[k];
                i_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(40, 1);
                    // Some bursts run back to back with no gap at all.
                    gap_left   <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stalls on a pattern of its own, and once holds off for a
    // long stretch while results are in flight so the pipeline backs up.
    // ------------------------------------------------------------------
    int  stall_mode   = 0;
    int  mode_left    = 0;
    int  hold_left    = 0;
    bit  hold_done    = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (!hold_done && expected_scales.size() >= 20) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            i_stall   <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(3, 0);
                mode_left  <= $urandom_range(60, 5);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: begin
                    i_stall <= 1'b0;
                end
                1: begin
                    i_stall <= ($urandom_range(3, 0) == 0);
                end
                2: begin
                    i_stall <= ($urandom_range(1, 0) == 0);
                end
                default: begin
                    i_stall <= ($urandom_range(4, 0) != 0);
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every result taken is compared with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        scales_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_scales.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result item: x=%h y=%h z=%h",
                             o_scale_x, o_scale_y, o_scale_z);
            end else begin
                want = expected_scales.pop_front();
                if (o_scale_x !== want.sx || o_scale_y !== want.sy ||
                    o_scale_z !== want.sz) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Scale mismatch: expected x=%h y=%h z=%h, got x=%h y=%h z=%h",
                                 want.sx, want.sy, want.sz,
                                 o_scale_x, o_scale_y, o_scale_z);
                end
            end
        end
    end

    // A cycle counter guards against a hung pipeline.
    int cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic write_eps(input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_EPS;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_eps = value;
    endtask

    // Waits until every queued item has gone in and every result has come out.
    task automatic drain();
        while (pending_mats.size() > 0 || expected_scales.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic matrix_t mat_of(input logic [31:0] a, b, c, d, e, f, g, h, k);
        matrix_t m;
        m.e = '{a, b, c, d, e, f, g, h, k};
        return m;
    endfunction

    // Element values drawn from several magnitudes so that the threshold,
    // saturation and wide products are all exercised.
    function automatic logic [31:0] rand_elem(input int mag);
        case (mag)
            0: return $urandom();
            1: return $urandom_range(32'h0004_0000, 0) - 32'h0002_0000;
            2: return $urandom_range(32'h0000_0100, 0) - 32'h0000_0080;
            default: return ($urandom_range(1, 0) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic matrix_t rand_matrix();
        matrix_t     m;
        int          kind, mag;
        logic [31:0] f;
        kind = $urandom_range(7, 0);
        mag  = $urandom_range(2, 0);
        if ($urandom_range(15, 0) == 0) mag = 3;
        for (int k = 0; k < 9; k++) m.e[k] = rand_elem(mag);
        case (kind)
            1: begin
                // First column zero.
                for (int r = 0; r < 3; r++) m.e[3*r] = '0;
            end
            2: begin
                // Second column a multiple of the first.
                f = $urandom_range(4, 0) - 2;
                for (int r = 0; r < 3; r++) m.e[3*r+1] = m.e[3*r] * f;
            end
            3: begin
                // Third column a combination of the first two.
                for (int r = 0; r < 3; r++) m.e[3*r+2] = m.e[3*r] - m.e[3*r+1];
            end
            4: begin
                // First two columns zero.
                for (int r = 0; r < 3; r++) begin
                    m.e[3*r]   = '0;
                    m.e[3*r+1] = '0;
                end
            end
            5: begin
                // Column a zero, c parallel to b.
                for (int r = 0; r < 3; r++) begin
                    m.e[3*r]   = '0;
                    m.e[3*r+2] = -m.e[3*r+1];
                end
            end
            default: begin
            end
        endcase
        return m;
    endfunction

    task automatic queue_random(input int count);
        for (int n = 0; n < count; n++) pending_mats.push_back(rand_matrix());
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        logic [31:0] one, mone, mx, mn;
        one  = 32'h0001_0000;
        mone = 32'hFFFF_0000;
        mx   = 32'h7FFF_FFFF;
        mn   = 32'h8000_0000;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items at the reset threshold of one.
        pending_mats.push_back(mat_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_mats.push_back(mat_of(one, 0, 0, 0, one, 0, 0, 0, one));
        // A left-handed basis negates all three scales.
        pending_mats.push_back(mat_of(mone, 0, 0, 0, one, 0, 0, 0, one));
        pending_mats.push_back(mat_of(one, 0, 0, 0, one, 0, 0, 0, mone));
        // Extreme elements push the roots into saturation.
        pending_mats.push_back(mat_of(mx, mx, mx, mx, mx, mx, mx, mx, mx));
        pending_mats.push_back(mat_of(mn, mn, mn, mn, mn, mn, mn, mn, mn));
        pending_mats.push_back(mat_of(mx, 0, 0, 0, mn, 0, 0, 0, mx));
        pending_mats.push_back(mat_of(mn, 0, 0, 0, mn, 0, 0, 0, mn));
        pending_mats.push_back(mat_of(mx, mn, mx, mn, mx, mn, mx, mn, mx));
        // Second column parallel to the first.
        pending_mats.push_back(mat_of(one, 2*one, 0, one, 2*one, one, 0, 0, one));
        // Third column in the plane of the first two.
        pending_mats.push_back(mat_of(one, 0, one, 0, one, one, 0, 0, 0));
        // First column zero, second usable, then both zero.
        pending_mats.push_back(mat_of(0, one, one, 0, 0, one, 0, 0, 3*one));
        pending_mats.push_back(mat_of(0, 0, one, 0, 0, 2*one, 0, 0, 2*one));
        pending_mats.push_back(mat_of(0, 0, mx, 0, 0, mx, 0, 0, mx));
        // Columns just at and just above the threshold of one.
        pending_mats.push_back(mat_of(1, 0, 0, 0, 1, 0, 0, 0, 1));
        pending_mats.push_back(mat_of(1, 0, 0, 1, 1, 0, 0, 0, 1));
        pending_mats.push_back(mat_of(32'hFFFF_FFFF, 1, 1, 1, 32'hFFFF_FFFF, 1, 1, 1, 2));
        pending_mats.push_back(mat_of(3*one, one, 0, 0, 2*one, one, one, 0, mone));
        drain();

        // Phases at several thresholds, the extremes among them. Between
        // phases the sender pauses until every result has come back.
        write_eps(32'd0);
        pending_mats.push_back(mat_of(1, 0, 0, 0, 1, 0, 0, 0, 1));
        pending_mats.push_back(mat_of(0, 0, 1, 0, 0, 0, 0, 0, 0));
        queue_random(180);
        drain();

        write_eps(32'hFFFF_FFFF);
        pending_mats.push_back(mat_of(one, 0, 0, 0, one, 0, 0, 0, one));
        pending_mats.push_back(mat_of(mx, 0, 0, 0, mx, 0, 0, 0, mx));
        queue_random(180);
        drain();

        write_eps(32'h0001_0000);
        queue_random(220);
        drain();

        write_eps($urandom());
        queue_random(200);
        drain();

        write_eps(EPS_RESET);
        queue_random(220);
        drain();

        repeat (150) @(posedge i_clk);
        if (mismatches == 0 && expected_scales.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
